### design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/aat_pkg.sv
// Package: types, constants and helpers of the transformed bounding box unit.
`default_nettype none

package aat_pkg;

  localparam int COEF_W    = 16;                    // Q4.12 coefficient / Q8.8 value
  localparam int PROD_W    = 2 * COEF_W;            // one coefficient times one coordinate
  localparam int ACC_W     = PROD_W + 3;            // three products, translation, rounding
  localparam int Q_SHIFT   = 12;                    // Q.20 -> Q8.8
  localparam int Q_W       = ACC_W - Q_SHIFT;       // width after the shift
  localparam int ROW_W     = 4 * COEF_W;
  localparam int ROUND_HALF = 2048;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ROW_X = 2'd0;
  localparam reg_idx_t REG_ROW_Y = 2'd1;
  localparam reg_idx_t REG_ROW_Z = 2'd2;

  typedef logic [COEF_W-1:0]         q88_t;
  typedef q88_t [2:0]                vec3_t;      // [axis]
  typedef logic [ROW_W-1:0]          row_t;
  typedef row_t [2:0]                rows_t;      // [output axis]
  typedef logic [PROD_W-1:0]         prod_t;
  typedef prod_t [2:0][2:0]          prod_mat_t;  // [output axis][input coord]

  // Saturate a floored Q8.8 value to 16 bits.
  function automatic q88_t sat_q88(input logic [Q_W-1:0] q);
    logic ovf_pos;
    logic ovf_neg;
    ovf_pos = !q[Q_W-1] && (|q[Q_W-2:COEF_W-1]);
    ovf_neg =  q[Q_W-1] && !(&q[Q_W-2:COEF_W-1]);
    if (ovf_pos) begin
      sat_q88 = 16'h7fff;
    end else if (ovf_neg) begin
      sat_q88 = 16'h8000;
    end else begin
      sat_q88 = q[COEF_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### design/aat_if.sv
// Box transaction interfaces for the input and result channels.
`default_nettype none

interface aat_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_min_x;
  logic signed [15:0] in_min_y;
  logic signed [15:0] in_min_z;
  logic signed [15:0] in_max_x;
  logic signed [15:0] in_max_y;
  logic signed [15:0] in_max_z;

  modport source (output valid, in_min_x, in_min_y, in_min_z,
                  in_max_x, in_max_y, in_max_z, input ready);
  modport sink   (input valid, in_min_x, in_min_y, in_min_z,
                  in_max_x, in_max_y, in_max_z, output ready);
endinterface

interface aat_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_min_x;
  logic signed [15:0] out_min_y;
  logic signed [15:0] out_min_z;
  logic signed [15:0] out_max_x;
  logic signed [15:0] out_max_y;
  logic signed [15:0] out_max_z;

  modport source (output valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, input ready);
  modport sink   (input valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, output ready);
endinterface

`default_nettype wire

### design/aabb_affine_transform.sv
// Top level of the transformed axis-aligned bounding box unit.
// Usage:
//  - in_box carries one box per transaction: min and max corner, signed Q8.8.
//  - out_box returns the box enclosing the eight corners after the affine
//    transform held in row_x/row_y/row_z, Q8.8, rounded and saturated.
//  - cfg_we/cfg_index/cfg_wdata write one 64-bit row per cycle; index 3 is
//    ignored. Write only while no transaction is in flight.
//  - Path: a box accepted into the input register passes the product, the
//    min/max select and the sum/result registers on its way to out_box.
//  - Throughput: one box per cycle; each of the four register stages takes a
//    new box whenever it is empty or its contents move on that cycle.
//  - Stall: when out_box.ready is low the result holds; bubbles upstream
//    still fill, so up to four boxes are held before in_box.ready drops.
//  - Reset (rst_n low, synchronous): all stages empty, rows return to the
//    identity transform with zero translation.
`default_nettype none

module aabb_affine_transform (
  input  logic              clk,
  input  logic              rst_n,
  aat_in_if.sink            in_box,
  aat_out_if.source         out_box,
  input  logic              cfg_we,
  input  aat_pkg::reg_idx_t cfg_index,
  input  aat_pkg::row_t     cfg_wdata
);
  import aat_pkg::*;

  // Configuration rows
  rows_t rows_r;
  rows_t rows_nxt;

  always_comb begin
    rows_nxt = rows_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X: rows_nxt[0] = cfg_wdata;
        REG_ROW_Y: rows_nxt[1] = cfg_wdata;
        REG_ROW_Z: rows_nxt[2] = cfg_wdata;
        default:   rows_nxt    = rows_r;   // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= {ROW_Z_RESET, ROW_Y_RESET, ROW_X_RESET};
    end else begin
      rows_r <= rows_nxt;
    end
  end

  // Stage occupancy and per-stage enables: a stage loads when it is empty
  // or its contents move on this cycle.
  logic v0_r, v1_r, v2_r, vo_r;
  logic v0_nxt, v1_nxt, v2_nxt, vo_nxt;
  logic en0, en1, en2, en3;

  assign en3 = !vo_r || out_box.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_box.ready = en0;

  always_comb begin
    v0_nxt = en0 ? in_box.valid : v0_r;
    v1_nxt = en1 ? v0_r : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
    vo_nxt = en3 ? v2_r : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  // Input register
  vec3_t lo_r, hi_r;
  vec3_t lo_nxt, hi_nxt;

  assign lo_nxt = {in_box.in_min_z, in_box.in_min_y, in_box.in_min_x};
  assign hi_nxt = {in_box.in_max_z, in_box.in_max_y, in_box.in_max_x};

  always_ff @(posedge clk) begin
    if (en0) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  // Datapath: the bound of a linear form over the box corners is the sum,
  // term by term, of the smaller (larger) of coefficient*min and
  // coefficient*max. Rounding and saturation are monotone, so they follow.
  prod_mat_t prod_lo, prod_hi;
  prod_mat_t tmin, tmax;
  vec3_t     res_min, res_max;

  aat_prod u_prod (
    .clk       (clk),
    .en        (en1),
    .rows      (rows_r),
    .lo        (lo_r),
    .hi        (hi_r),
    .prod_lo_r (prod_lo),
    .prod_hi_r (prod_hi)
  );

  aat_sel u_sel (
    .clk     (clk),
    .en      (en2),
    .prod_lo (prod_lo),
    .prod_hi (prod_hi),
    .tmin_r  (tmin),
    .tmax_r  (tmax)
  );

  aat_sum u_sum (
    .clk       (clk),
    .en        (en3),
    .rows      (rows_r),
    .tmin      (tmin),
    .tmax      (tmax),
    .res_min_r (res_min),
    .res_max_r (res_max)
  );

  // Result channel
  assign out_box.valid     = vo_r;
  assign out_box.out_min_x = res_min[0];
  assign out_box.out_min_y = res_min[1];
  assign out_box.out_min_z = res_min[2];
  assign out_box.out_max_x = res_max[0];
  assign out_box.out_max_y = res_max[1];
  assign out_box.out_max_z = res_max[2];

endmodule

`default_nettype wire

### design/aat_prod.sv
// Product stage: every coefficient times both box bounds, registered.
`default_nettype none

module aat_prod (
  input  logic              clk,
  input  logic              en,
  input  aat_pkg::rows_t    rows,
  input  aat_pkg::vec3_t    lo,
  input  aat_pkg::vec3_t    hi,
  output aat_pkg::prod_mat_t prod_lo_r,
  output aat_pkg::prod_mat_t prod_hi_r
);
  import aat_pkg::*;

  prod_mat_t prod_lo_nxt;
  prod_mat_t prod_hi_nxt;

  // Both operands sign-extended to the product width; the exact product fits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_lo_nxt[i][j] = PROD_W'($signed(rows[i][COEF_W*j +: COEF_W]))
                          * PROD_W'($signed(lo[j]));
        prod_hi_nxt[i][j] = PROD_W'($signed(rows[i][COEF_W*j +: COEF_W]))
                          * PROD_W'($signed(hi[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo_r <= prod_lo_nxt;
      prod_hi_r <= prod_hi_nxt;
    end
  end

endmodule

`default_nettype wire

### design/aat_sel.sv
// Select stage: per term, the smaller and larger of the two bound products.
`default_nettype none

module aat_sel (
  input  logic               clk,
  input  logic               en,
  input  aat_pkg::prod_mat_t prod_lo,
  input  aat_pkg::prod_mat_t prod_hi,
  output aat_pkg::prod_mat_t tmin_r,
  output aat_pkg::prod_mat_t tmax_r
);
  import aat_pkg::*;

  prod_mat_t tmin_nxt;
  prod_mat_t tmax_nxt;

  // A negative coefficient swaps which bound gives the minimum.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ($signed(prod_lo[i][j]) < $signed(prod_hi[i][j])) begin
          tmin_nxt[i][j] = prod_lo[i][j];
          tmax_nxt[i][j] = prod_hi[i][j];
        end else begin
          tmin_nxt[i][j] = prod_hi[i][j];
          tmax_nxt[i][j] = prod_lo[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmin_r <= tmin_nxt;
      tmax_r <= tmax_nxt;
    end
  end

endmodule

`default_nettype wire

### design/aat_sum.sv
// Sum stage: add terms and translation, round to Q8.8, saturate; result register.
`default_nettype none

module aat_sum (
  input  logic               clk,
  input  logic               en,
  input  aat_pkg::rows_t     rows,
  input  aat_pkg::prod_mat_t tmin,
  input  aat_pkg::prod_mat_t tmax,
  output aat_pkg::vec3_t     res_min_r,
  output aat_pkg::vec3_t     res_max_r
);
  import aat_pkg::*;

  logic signed [ACC_W-1:0] acc_min [3];
  logic signed [ACC_W-1:0] acc_max [3];
  logic signed [ACC_W-1:0] trans   [3];
  vec3_t                   res_min_nxt;
  vec3_t                   res_max_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trans[i] = (ACC_W'($signed(rows[i][ROW_W-1 -: COEF_W])) <<< Q_SHIFT)
                 + ACC_W'(ROUND_HALF);
      acc_min[i] = ACC_W'($signed(tmin[i][0])) + ACC_W'($signed(tmin[i][1]))
                 + ACC_W'($signed(tmin[i][2])) + trans[i];
      acc_max[i] = ACC_W'($signed(tmax[i][0])) + ACC_W'($signed(tmax[i][1]))
                 + ACC_W'($signed(tmax[i][2])) + trans[i];
      // dropping the low bits floors, so with the half added this rounds ties up
      res_min_nxt[i] = sat_q88(acc_min[i][ACC_W-1:Q_SHIFT]);
      res_max_nxt[i] = sat_q88(acc_max[i][ACC_W-1:Q_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_min_r <= res_min_nxt;
      res_max_r <= res_max_nxt;
    end
  end

endmodule

`default_nettype wire

### design/aat_checker.sv
// Port-level checker for the transformed bounding box unit, with its bind.
`default_nettype none
`include "assert_macros.svh"

module aat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_min_x,
  input logic [15:0] out_max_x
);

  // Transactions accepted but not yet delivered.
  logic [3:0] occ_r;
  logic [3:0] occ_nxt;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_fire && !out_fire) begin
      occ_nxt = occ_r + 4'd1;
    end else if (!in_fire && out_fire) begin
      occ_nxt = occ_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 4'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `AAT_ASSERT_NOW(a_no_phantom, out_valid, occ_r != 4'd0, "result with nothing in flight")
  `AAT_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= 4'd4, "more transactions held than stages")
  `AAT_ASSERT_NOW(a_ready_empty, occ_r == 4'd0, in_ready, "input stalled with unit empty")
  `AAT_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
                  out_valid && $stable(out_min_x) && $stable(out_max_x),
                  "stalled result changed")

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_box.valid),
  .in_ready  (in_box.ready),
  .out_valid (out_box.valid),
  .out_ready (out_box.ready),
  .out_min_x (out_box.out_min_x),
  .out_max_x (out_box.out_max_x)
);

`default_nettype wire

### dv/aabb_affine_transform_tb.sv
`timescale 1ns / 1ps
// Testbench of the transformed bounding box unit: directed box table, then random boxes and rows.

module aabb_affine_transform_tb;
  import aat_pkg::*;

  // Run shape: 19 directed boxes plus 8 phases of random boxes, about 1850 in all.
  localparam int       RANDOM_PHASES   = 8;
  localparam int       ITEMS_PER_PHASE = 229;
  localparam int       MAX_IDLE        = 10;  // longest gap or stall drawn per transaction
  localparam int       LONG_HOLD       = 40;  // result side held off well past pipeline depth
  localparam int       DRAIN_CYCLES    = 8;   // four stages of latency plus margin
  localparam reg_idx_t REG_UNUSED      = 2'd3;  // decoded by nothing, writes must be dropped
  localparam int       LO              = -32768;
  localparam int       HI              = 32767;
  localparam q88_t     Q_MIN           = 16'h8000;
  localparam q88_t     Q_MAX           = 16'h7fff;

  typedef struct packed {
    q88_t min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;

  // Same bits as box_t, indexed 5 (min_x) down to 0 (max_z) for field-wise checks.
  typedef q88_t [5:0] box_words_t;

  // Row setting applied before a directed box; SET_KEEP leaves the rows alone.
  typedef enum logic [2:0] {
    SET_KEEP, SET_POKE_UNUSED, SET_HALF, SET_MAX, SET_MIN, SET_ZERO
  } row_set_e;

  typedef struct packed {
    row_set_e rows;
    box_t     stim;
    logic     typed;  // want holds a hand-worked result; otherwise predict
    box_t     want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  reg_idx_t cfg_index;
  row_t     cfg_wdata;

  aat_in_if  in_ch ();
  aat_out_if out_ch ();

  aabb_affine_transform dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_box    (in_ch),
    .out_box   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the three transform rows, kept in step with every cfg write.
  row_t     row_model [3];
  box_t     expected_boxes [$];   // predicted results, oldest first
  dir_row_t directed [19];
  string    field_names [6] = '{"max_z", "max_y", "max_x", "min_z", "min_y", "min_x"};

  int mismatches         = 0;
  int results_seen       = 0;
  int sender_max_gap     = MAX_IDLE;
  int recv_max_stall     = MAX_IDLE;
  int long_holds_pending = 0;     // requests for one long result-side hold

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic box_t box_of(input int lx, input int ly, input int lz,
                                  input int hx, input int hy, input int hz);
    return '{lx[15:0], ly[15:0], lz[15:0], hx[15:0], hy[15:0], hz[15:0]};
  endfunction

  // One output axis at one corner: exact Q.20 sum, round half up to Q8.8, saturate.
  function automatic q88_t axis_q88(input row_t row, input q88_t x, input q88_t y,
                                    input q88_t z);
    logic signed [47:0] cx, cy, cz, tr, px, py, pz, acc, q;
    cx  = $signed(row[15:0]);
    cy  = $signed(row[31:16]);
    cz  = $signed(row[47:32]);
    tr  = $signed(row[63:48]);
    px  = $signed(x);
    py  = $signed(y);
    pz  = $signed(z);
    acc = cx * px + cy * py + cz * pz + (tr <<< Q_SHIFT) + ROUND_HALF;
    q   = acc >>> Q_SHIFT;       // arithmetic shift gives the floor
    if (q > 48'sd32767) return Q_MAX;
    if (q < -48'sd32768) return Q_MIN;
    return q[15:0];
  endfunction

  // Enclosing box of all eight transformed corners; min and max kept independently,
  // so an inverted input box still yields min <= max.
  function automatic box_t transformed_box(input box_t b);
    q88_t               lo [3];
    q88_t               hi [3];
    q88_t               x, y, z;
    logic signed [15:0] v;
    logic signed [15:0] mn [3];
    logic signed [15:0] mx [3];
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    for (int k = 0; k < 8; k++) begin
      x = (k & 4) ? hi[0] : lo[0];
      y = (k & 2) ? hi[1] : lo[1];
      z = (k & 1) ? hi[2] : lo[2];
      for (int a = 0; a < 3; a++) begin
        v = axis_q88(row_model[a], x, y, z);
        if (k == 0 || v < mn[a]) mn[a] = v;
        if (k == 0 || v > mx[a]) mx[a] = v;
      end
    end
    return '{mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]};
  endfunction

  // Random row: mostly coefficients within +/-1.0 so results stay unsaturated,
  // with some zero and some full-range fields; wide gives all 64 bits at random.
  function automatic row_t draw_row(input bit wide);
    row_t r;
    int   v;
    if (wide) return {$urandom, $urandom};
    for (int f = 0; f < 4; f++) begin
      case ($urandom_range(0, 7))
        0: r[f*16 +: 16] = $urandom;
        1: r[f*16 +: 16] = '0;
        default: begin
          v = $urandom_range(0, 8192) - 4096;
          r[f*16 +: 16] = v[15:0];
        end
      endcase
    end
    return r;
  endfunction

  // Random box: mostly well-formed and mid-range, some full-range fields, some inverted.
  function automatic box_t draw_box();
    q88_t lo [3];
    q88_t hi [3];
    q88_t t;
    int   mode;
    int   base;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (mode < 2) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        base  = $urandom_range(0, 16383) - 8192;
        lo[a] = base[15:0];
        hi[a] = lo[a] + 16'($urandom_range(0, 4096));
        if (mode == 2 && $urandom_range(0, 1)) begin
          t     = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
    end
    return '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
  endfunction

  // Offer one box after an idle gap; the prediction is queued at the accepting edge.
  // Valid is left high, so the caller either offers again or lowers it.
  task automatic offer_box(input box_t b, input box_t want, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_min_x <= b.min_x;
    in_ch.in_min_y <= b.min_y;
    in_ch.in_min_z <= b.min_z;
    in_ch.in_max_x <= b.max_x;
    in_ch.in_max_y <= b.max_y;
    in_ch.in_max_z <= b.max_z;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_boxes.push_back(want);
  endtask

  // Stop offering, wait for every predicted result, then let the pipeline empty.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    wait (expected_boxes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write per cycle; cfg_we stays high across back-to-back writes.
  task automatic write_reg(input reg_idx_t idx, input row_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx != REG_UNUSED) row_model[idx] = val;
  endtask

  task automatic program_rows(input row_t rx, input row_t ry, input row_t rz, input bit poke);
    if (poke) write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stall per transaction, occasional long hold, field-wise compare.
  initial begin : result_sink
    box_t       got;
    box_t       want;
    box_words_t gw;
    box_words_t ww;
    int         stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_holds_pending > 0) begin
        long_holds_pending--;
        stall = LONG_HOLD;
      end else begin
        stall = $urandom_range(0, recv_max_stall);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got = '{out_ch.out_min_x, out_ch.out_min_y, out_ch.out_min_z,
              out_ch.out_max_x, out_ch.out_max_y, out_ch.out_max_z};
      if (expected_boxes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = expected_boxes.pop_front();
        gw   = got;
        ww   = want;
        for (int f = 5; f >= 0; f--) begin
          if (gw[f] !== ww[f]) begin
            report_mismatch($sformatf("result %0d %s: want %0d got %0d", results_seen,
                                      field_names[f], $signed(ww[f]), $signed(gw[f])));
          end
        end
      end
      results_seen++;
    end
  end

  // Main sequence: reset, directed table, then random phases under fresh rows.
  initial begin : stimulus
    box_t b;
    int   pause_at;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_min_x <= '0;
    in_ch.in_min_y <= '0;
    in_ch.in_min_z <= '0;
    in_ch.in_max_x <= '0;
    in_ch.in_max_y <= '0;
    in_ch.in_max_z <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_ROW_X;
    cfg_wdata      <= '0;
    row_model = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};

    // Results typed in where the rows make them obvious: identity after reset,
    // half-scale diagonal for the rounding tie, all-max / all-min rows for
    // saturation, zero rows for a constant zero box.
    directed = '{
      // identity: output box is the input box with min/max put in order
      '{SET_KEEP, box_of(0, 0, 0, 0, 0, 0), 1'b1, box_of(0, 0, 0, 0, 0, 0)},
      '{SET_KEEP, box_of(LO, LO, LO, HI, HI, HI), 1'b1, box_of(LO, LO, LO, HI, HI, HI)},
      '{SET_KEEP, box_of(HI, HI, HI, LO, LO, LO), 1'b1, box_of(LO, LO, LO, HI, HI, HI)},
      '{SET_KEEP, box_of(100, -200, 300, 400, 50, 301), 1'b1,
        box_of(100, -200, 300, 400, 50, 301)},
      '{SET_KEEP, box_of(100, 5, -7, -100, 5, 9), 1'b1, box_of(-100, 5, -7, 100, 5, 9)},
      '{SET_KEEP, box_of(LO, LO, LO, LO, LO, LO), 1'b1, box_of(LO, LO, LO, LO, LO, LO)},
      '{SET_KEEP, box_of(HI, HI, HI, HI, HI, HI), 1'b1, box_of(HI, HI, HI, HI, HI, HI)},
      '{SET_KEEP, box_of(21845, 21845, 21845, -21846, -21846, -21846), 1'b1,
        box_of(-21846, -21846, -21846, 21845, 21845, 21845)},
      // write to the unused index must leave the identity in place
      '{SET_POKE_UNUSED, box_of(-1, -2, -3, 1, 2, 3), 1'b1, box_of(-1, -2, -3, 1, 2, 3)},
      // half scale: -0.5 lsb rounds up to 0, +0.5 lsb to 1
      '{SET_HALF, box_of(-1, -1, -1, 1, 1, 1), 1'b1, box_of(0, 0, 0, 1, 1, 1)},
      '{SET_KEEP, box_of(-3, -3, -3, 3, 3, 3), 1'b0, '0},
      '{SET_KEEP, box_of(LO, LO, LO, HI, HI, HI), 1'b0, '0},
      '{SET_KEEP, box_of(-255, 77, 1000, 3, -9, 1001), 1'b0, '0},
      // every field at its positive extreme: both ends saturate
      '{SET_MAX, box_of(LO, LO, LO, HI, HI, HI), 1'b1, box_of(LO, LO, LO, HI, HI, HI)},
      '{SET_KEEP, box_of(0, 0, 0, 0, 0, 0), 1'b1, box_of(HI, HI, HI, HI, HI, HI)},
      // every field at its negative extreme
      '{SET_MIN, box_of(LO, LO, LO, HI, HI, HI), 1'b1, box_of(LO, LO, LO, HI, HI, HI)},
      '{SET_KEEP, box_of(0, 0, 0, 0, 0, 0), 1'b1, box_of(LO, LO, LO, LO, LO, LO)},
      // all-zero rows collapse any box to the origin
      '{SET_ZERO, box_of(LO, LO, LO, HI, HI, HI), 1'b1, box_of(0, 0, 0, 0, 0, 0)},
      '{SET_KEEP, box_of(1234, -4321, 77, -5, 6, 7), 1'b1, box_of(0, 0, 0, 0, 0, 0)}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].rows != SET_KEEP) begin
        drain_pipeline();
        case (directed[i].rows)
          SET_POKE_UNUSED: begin
            write_reg(REG_UNUSED, '1);
            cfg_we <= 1'b0;
          end
          SET_HALF: program_rows(64'h0000_0000_0000_0800, 64'h0000_0000_0800_0000,
                                 64'h0000_0800_0000_0000, 1'b0);
          SET_MAX:  program_rows(64'h7fff_7fff_7fff_7fff,
                                 64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff, 1'b0);
          SET_MIN:  program_rows(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                                 64'h8000_8000_8000_8000, 1'b0);
          default:  program_rows('0, '0, '0, 1'b0);
        endcase
      end
      b = directed[i].stim;
      offer_box(b, directed[i].typed ? directed[i].want : transformed_box(b),
                $urandom_range(0, MAX_IDLE));
    end

    // Random phases. Idle pattern cycles through: both sides idle, neither idles,
    // back-to-back offers against a stalling result side (with one long hold so the
    // pipeline fills and input ready drops), and a gappy sender into an eager sink.
    // First phase uses fully random rows, which mostly saturates.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_pipeline();
      program_rows(draw_row(p == 0), draw_row(p == 0), draw_row(p == 0),
                   1'($urandom_range(0, 1)));
      sender_max_gap = (p % 4 == 1 || p % 4 == 2) ? 0 : MAX_IDLE;
      recv_max_stall = (p % 4 == 1 || p % 4 == 3) ? 0 : MAX_IDLE;
      if (p % 4 == 2) long_holds_pending++;
      pause_at = $urandom_range(20, ITEMS_PER_PHASE - 20);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // once per phase the sender stops until every result is back
        if (i == pause_at) drain_pipeline();
        b = draw_box();
        offer_box(b, transformed_box(b), $urandom_range(0, sender_max_gap));
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
